// File: rtl/mhv_pkg.sv
// ----------------------------------------------------------------------------
// mhv_pkg
// Shared types and constants of the module header validator.
// ----------------------------------------------------------------------------
package mhv_pkg;

	localparam int MAGIC_BYTES  = 8;
	localparam int FIELD_BYTES  = 8;
	localparam int LEGACY_BYTES = 2;

	localparam logic [15:0] MAGIC_CNT   = 16'(MAGIC_BYTES);
	localparam logic [15:0] FIELD_CNT   = 16'(FIELD_BYTES);
	localparam logic [15:0] SMALL_HDR   = 16'(MAGIC_BYTES + FIELD_BYTES);
	localparam logic [15:0] MAJOR_MASK  = 16'hFF00;

	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MAGIC      = 3'd0,
		REG_LEGACY     = 3'd1,
		REG_MAJOR      = 3'd2,
		REG_MIN_SIZE   = 3'd3,
		REG_ENCODING   = 3'd4,
		REG_BYTE_ORDER = 3'd5,
		REG_WORD_BITS  = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_STRUCTURE = 3'd2,
		ST_VERSION   = 3'd3,
		ST_ORDER     = 3'd4,
		ST_ENCODING  = 3'd5,
		ST_WORD_SIZE = 3'd6
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_MAGIC  = 5'b00010,
		PH_FIELDS = 5'b00100,
		PH_SKIP   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [63:0] magic_value;
		logic [15:0] legacy_signature;
		logic [7:0]  expected_major;
		logic [15:0] min_header_size;
		logic [7:0]  host_encoding;
		logic [7:0]  host_byte_order;
		logic [7:0]  host_word_bits;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] format_version;
		logic [15:0] header_size;
		logic [7:0]  header_flags;
	} result_t;

endpackage

// File: rtl/module_header_validator.sv
// ----------------------------------------------------------------------------
// module_header_validator
// Streaming check of a module file header, one byte per item, one verdict per module.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side keeps up: an item is held in an
// input register, parsed there, and its verdict (if any) shows up in the output
// register the cycle after it is parsed. A stalled output register holds the input
// register, so one more item is still taken while a verdict waits. Verdicts come out
// when the header is settled, the stream ends early, or a frame start arrives with
// the end flag; items outside a module give nothing.
module module_header_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] format_version,
	output logic [15:0] header_size,
	output logic [7:0]  header_flags
);

	mhv_pkg::cfg_t    cfg_q;
	mhv_pkg::item_t   item_s1;
	logic             valid_s1;
	mhv_pkg::result_t res_s2;
	logic             valid_s2;
	logic             advance;
	logic             parse_en;
	logic             res_valid;
	mhv_pkg::result_t res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic_value      <= '0;
			cfg_q.legacy_signature <= '0;
			cfg_q.expected_major   <= '0;
			cfg_q.min_header_size  <= 16'd16;
			cfg_q.host_encoding    <= '0;
			cfg_q.host_byte_order  <= '0;
			cfg_q.host_word_bits   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mhv_pkg::REG_MAGIC:      cfg_q.magic_value      <= wr_data;
				mhv_pkg::REG_LEGACY:     cfg_q.legacy_signature <= wr_data[15:0];
				mhv_pkg::REG_MAJOR:      cfg_q.expected_major   <= wr_data[7:0];
				mhv_pkg::REG_MIN_SIZE:   cfg_q.min_header_size  <= wr_data[15:0];
				mhv_pkg::REG_ENCODING:   cfg_q.host_encoding    <= wr_data[7:0];
				mhv_pkg::REG_BYTE_ORDER: cfg_q.host_byte_order  <= wr_data[7:0];
				mhv_pkg::REG_WORD_BITS:  cfg_q.host_word_bits   <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign parse_en = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data_byte   <= data_byte;
			item_s1.frame_start <= frame_start;
			item_s1.stream_end  <= stream_end;
		end
	end

	mhv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (parse_en),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= parse_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (parse_en && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign format_version = res_s2.format_version;
	assign header_size    = res_s2.header_size;
	assign header_flags   = res_s2.header_flags;

endmodule

// File: rtl/mhv_parser.sv
// ----------------------------------------------------------------------------
// mhv_parser
// Header parse state and per-byte next-state logic; at most one verdict per item.
// ----------------------------------------------------------------------------
module mhv_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  mhv_pkg::item_t   item,
	input  mhv_pkg::cfg_t    cfg,
	output logic             res_valid,
	output mhv_pkg::result_t res
);

	mhv_pkg::phase_t phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic        mok_q, mok_d;
	logic        sok_q, sok_d;
	logic [15:0] ver_q, ver_d;
	logic [15:0] siz_q, siz_d;
	logic [7:0]  enc_q, enc_d;
	logic [7:0]  ord_q, ord_d;
	logic [7:0]  wb_q, wb_d;
	logic [7:0]  flg_q, flg_d;

	logic            emit;
	mhv_pkg::status_t st;
	logic [3:0]      nread;
	logic [7:0]      b;

	function automatic mhv_pkg::status_t compat(input logic [7:0] ord, input logic [7:0] enc,
			input logic [7:0] wb, input mhv_pkg::cfg_t c);
		mhv_pkg::status_t s;
		if (ord != c.host_byte_order) begin
			s = mhv_pkg::ST_ORDER;
		end else if (enc != c.host_encoding) begin
			s = mhv_pkg::ST_ENCODING;
		end else if (wb != c.host_word_bits) begin
			s = mhv_pkg::ST_WORD_SIZE;
		end else begin
			s = mhv_pkg::ST_OK;
		end
		return s;
	endfunction

	assign b = item.data_byte;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		mok_d   = mok_q;
		sok_d   = sok_q;
		ver_d   = ver_q;
		siz_d   = siz_q;
		enc_d   = enc_q;
		ord_d   = ord_q;
		wb_d    = wb_q;
		flg_d   = flg_q;
		emit    = 1'b0;
		st      = mhv_pkg::ST_OK;
		nread   = 4'd0;

		if (en && item.frame_start) begin
			cnt_d   = '0;
			mok_d   = 1'b1;
			sok_d   = 1'b1;
			ver_d   = '0;
			siz_d   = '0;
			enc_d   = '0;
			ord_d   = '0;
			wb_d    = '0;
			flg_d   = '0;
			phase_d = mhv_pkg::PH_MAGIC;
			if (item.stream_end) begin
				emit = 1'b1;
				st   = mhv_pkg::ST_NOT_FOUND;
			end
		end

		if (en && !emit) begin
			case (phase_d)
				mhv_pkg::PH_MAGIC: begin
					if (item.stream_end) begin
						// missing magic bytes count as zero
						for (int i = 0; i < 8; i++) begin
							if (i < mhv_pkg::MAGIC_BYTES && 16'(i) >= cnt_d
									&& cfg.magic_value[8*i +: 8] != 8'd0) begin
								mok_d = 1'b0;
							end
						end
						for (int i = 0; i < mhv_pkg::LEGACY_BYTES; i++) begin
							if (16'(i) >= cnt_d && cfg.legacy_signature[8*i +: 8] != 8'd0) begin
								sok_d = 1'b0;
							end
						end
						emit = 1'b1;
						st   = (!mok_d && sok_d) ? mhv_pkg::ST_VERSION : mhv_pkg::ST_STRUCTURE;
					end else begin
						if (b != cfg.magic_value[{cnt_d[2:0], 3'b000} +: 8]) begin
							mok_d = 1'b0;
						end
						if (cnt_d < 16'(mhv_pkg::LEGACY_BYTES)
								&& b != cfg.legacy_signature[{cnt_d[0], 3'b000} +: 8]) begin
							sok_d = 1'b0;
						end
						cnt_d = cnt_d + 16'd1;
						if (cnt_d >= mhv_pkg::MAGIC_CNT) begin
							if (!mok_d) begin
								emit = 1'b1;
								st   = sok_d ? mhv_pkg::ST_VERSION : mhv_pkg::ST_STRUCTURE;
							end else begin
								phase_d = mhv_pkg::PH_FIELDS;
								cnt_d   = '0;
							end
						end
					end
				end
				mhv_pkg::PH_FIELDS: begin
					if (item.stream_end) begin
						emit  = 1'b1;
						st    = mhv_pkg::ST_STRUCTURE;
						nread = cnt_d[3:0];
					end else begin
						case (cnt_d[2:0])
							3'd0:    ver_d = {8'd0, b};
							3'd1:    ver_d = {b, ver_d[7:0]};
							3'd2:    siz_d = {8'd0, b};
							3'd3:    siz_d = {b, siz_d[7:0]};
							3'd4:    enc_d = b;
							3'd5:    ord_d = b;
							3'd6:    wb_d  = b;
							default: flg_d = b;
						endcase
						cnt_d = cnt_d + 16'd1;
						if (cnt_d == mhv_pkg::FIELD_CNT) begin
							nread = 4'd8;
							if ((ver_d & mhv_pkg::MAJOR_MASK) != {cfg.expected_major, 8'd0}) begin
								emit = 1'b1;
								st   = mhv_pkg::ST_VERSION;
							end else if (siz_d < cfg.min_header_size) begin
								emit = 1'b1;
								st   = mhv_pkg::ST_STRUCTURE;
							end else if (siz_d > mhv_pkg::SMALL_HDR) begin
								phase_d = mhv_pkg::PH_SKIP;
								cnt_d   = mhv_pkg::SMALL_HDR;
							end else begin
								emit = 1'b1;
								st   = compat(ord_d, enc_d, wb_d, cfg);
							end
						end
					end
				end
				mhv_pkg::PH_SKIP: begin
					nread = 4'd8;
					if (item.stream_end) begin
						emit = 1'b1;
						st   = mhv_pkg::ST_STRUCTURE;
					end else begin
						cnt_d = cnt_d + 16'd1;
						if (cnt_d >= siz_d) begin
							emit = 1'b1;
							st   = compat(ord_d, enc_d, wb_d, cfg);
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (emit) begin
			phase_d = mhv_pkg::PH_DONE;
		end
	end

	assign res_valid          = emit;
	assign res.status         = st;
	assign res.format_version = (nread >= 4'd2) ? ver_d : 16'd0;
	assign res.header_size    = (nread >= 4'd4) ? siz_d : 16'd0;
	assign res.header_flags   = (nread >= 4'd8) ? flg_d : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mhv_pkg::PH_IDLE;
			cnt_q   <= '0;
			mok_q   <= 1'b1;
			sok_q   <= 1'b1;
			ver_q   <= '0;
			siz_q   <= '0;
			enc_q   <= '0;
			ord_q   <= '0;
			wb_q    <= '0;
			flg_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			mok_q   <= mok_d;
			sok_q   <= sok_d;
			ver_q   <= ver_d;
			siz_q   <= siz_d;
			enc_q   <= enc_d;
			ord_q   <= ord_d;
			wb_q    <= wb_d;
			flg_q   <= flg_d;
		end
	end

	a_done_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		en && res_valid |=> phase_q == mhv_pkg::PH_DONE)
		else $error("verdict given but parse not finished");

	a_quiet_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		en && !item.frame_start && (phase_q == mhv_pkg::PH_DONE || phase_q == mhv_pkg::PH_IDLE)
		|-> !res_valid)
		else $error("verdict outside a module");

	a_empty_module: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.frame_start && item.stream_end
		|-> res_valid && res.status == mhv_pkg::ST_NOT_FOUND)
		else $error("empty module not reported as not found");

	a_magic_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mhv_pkg::PH_MAGIC |-> cnt_q < mhv_pkg::MAGIC_CNT)
		else $error("magic byte count out of range");

	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == mhv_pkg::PH_FIELDS |-> cnt_q < mhv_pkg::FIELD_CNT)
		else $error("field byte count out of range");

endmodule
